// File: rtl/spi_flash_command_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// spi flash command sequencer - assertion macros
// shared property wrappers for the sequencer checks
// ----------------------------------------------------------------------------
`ifndef SPI_FLASH_COMMAND_SEQUENCER_TOP_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SFCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfcs check failed");

// next-cycle implication, checked outside reset
`define SFCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfcs check failed");

`endif

// File: rtl/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// sfcs_pkg
// types, opcodes and frame tables for the spi flash command sequencer
// ----------------------------------------------------------------------------
package sfcs_pkg;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_RET  = 2'd1,
    KIND_DATA = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_PROG  = 3'd1,
    OP_SE    = 3'd2,
    OP_CE    = 3'd3,
    OP_RDID  = 3'd4,
    OP_RAW   = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_READ   = 4'd1,
    PH_RDDATA = 4'd2,
    PH_ID     = 4'd3,
    PH_POLL   = 4'd4,
    PH_WRSR   = 4'd5,
    PH_WREN   = 4'd6,
    PH_PROG   = 4'd7,
    PH_PWAIT  = 4'd8,
    PH_PDATA  = 4'd9,
    PH_SE     = 4'd10,
    PH_CE     = 4'd11,
    PH_RWAIT  = 4'd12,
    PH_RAW    = 4'd13
  } phase_t;

  // flash opcodes and fixed bytes
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_PROG  = 8'h02;
  localparam logic [7:0] CMD_SE    = 8'h20;
  localparam logic [7:0] CMD_CE    = 8'hC7;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_WRSR  = 8'h01;
  localparam logic [7:0] CMD_RDID  = 8'h9F;
  localparam logic [7:0] SR_VALUE  = 8'h02;
  localparam logic [7:0] POLL_FILL = 8'hFF;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  op;
    logic [23:0] addr;
    logic [15:0] bytes;
    logic [1:0]  hidx;
    logic        poll_after;
  } st_t;

  localparam st_t ST_RESET = '{phase: PH_IDLE, op: 3'd0, addr: 24'd0, bytes: 16'd0,
                               hidx: 2'd0, poll_after: 1'b0};

  typedef struct packed {
    logic       bv;
    logic [7:0] bb;
    logic       sel;
    logic       rel;
  } bus_t;

  typedef struct packed {
    bus_t       bus;
    logic       host_valid;
    logic [7:0] host_byte;
    logic       need_data;
    logic       done_res;
  } res_t;

  function automatic logic [7:0] addr_byte(input logic [1:0] idx, input logic [23:0] addr);
    case (idx)
      2'd1:    addr_byte = addr[23:16];
      2'd2:    addr_byte = addr[15:8];
      default: addr_byte = addr[7:0];
    endcase
  endfunction

  function automatic logic [7:0] frame_byte(input phase_t ph, input logic [1:0] idx,
                                            input logic [23:0] addr);
    logic first;
    first = (idx == 2'd0);
    case (ph)
      PH_READ: frame_byte = first ? CMD_READ : addr_byte(idx, addr);
      PH_ID:   frame_byte = first ? CMD_RDID : 8'h00;
      PH_POLL: frame_byte = first ? CMD_RDSR : POLL_FILL;
      PH_WRSR: frame_byte = first ? CMD_WRSR : SR_VALUE;
      PH_WREN: frame_byte = CMD_WREN;
      PH_PROG: frame_byte = first ? CMD_PROG : addr_byte(idx, addr);
      PH_SE:   frame_byte = first ? CMD_SE : addr_byte(idx, addr);
      PH_CE:   frame_byte = CMD_CE;
      default: frame_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] frame_len(input phase_t ph);
    case (ph)
      PH_WREN, PH_CE:  frame_len = 3'd1;
      PH_POLL, PH_WRSR: frame_len = 3'd2;
      default:         frame_len = 3'd4;
    endcase
  endfunction

  // header byte of a frame, with chip-select framing
  function automatic bus_t header_bus(input phase_t ph, input logic [1:0] idx,
                                      input logic [23:0] addr, input logic bytes_zero);
    logic releases;
    case (ph)
      PH_PROG: releases = 1'b0;
      PH_READ: releases = bytes_zero;
      default: releases = 1'b1;
    endcase
    header_bus.bv  = 1'b1;
    header_bus.bb  = frame_byte(ph, idx, addr);
    header_bus.sel = (idx == 2'd0);
    header_bus.rel = (({1'b0, idx} + 3'd1) == frame_len(ph)) && releases;
  endfunction

endpackage

// File: rtl/sfcs_core.sv
// ----------------------------------------------------------------------------
// sfcs_core
// next-state and result logic for one item of the flash command sequencer
// ----------------------------------------------------------------------------
module sfcs_core #(
  parameter int CHUNK_BYTES = 256
) (
  input  logic [1:0]             kind,
  input  logic [2:0]             op,
  input  logic [23:0]            address,
  input  logic [15:0]            length,
  input  logic [7:0]             data,
  input  sfcs_pkg::st_t          state,
  input  logic [$clog2(CHUNK_BYTES+1)-1:0] chunk,
  output sfcs_pkg::st_t          state_next,
  output logic [$clog2(CHUNK_BYTES+1)-1:0] chunk_next,
  output logic                   res_valid,
  output sfcs_pkg::res_t         res
);

  localparam int CW = $clog2(CHUNK_BYTES + 1);

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_HDR,
    ACT_FILL,
    ACT_RAWB,
    ACT_PROGB,
    ACT_NEED,
    ACT_DONE
  } act_t;

  act_t          action;
  logic          got;
  logic          host_take;
  logic [2:0]    idx_inc;
  logic [15:0]   bytes_dec;
  logic [CW-1:0] chunk_dec;
  logic [CW-1:0] chunk_first;

  assign idx_inc     = {1'b0, state.hidx} + 3'd1;
  assign bytes_dec   = (state.bytes != 16'd0) ? state.bytes - 16'd1 : state.bytes;
  assign chunk_dec   = (chunk != '0) ? chunk - CW'(1) : chunk;
  assign chunk_first = (state.bytes < 16'(CHUNK_BYTES)) ? CW'(state.bytes)
                                                        : CW'(CHUNK_BYTES);

  // next state and chosen action
  always_comb begin
    state_next = state;
    chunk_next = chunk;
    action     = ACT_NONE;
    got        = 1'b0;
    host_take  = 1'b0;
    case (kind)
      sfcs_pkg::KIND_CMD: begin
        if (state.phase == sfcs_pkg::PH_IDLE) begin
          got                   = 1'b1;
          state_next.op         = op;
          state_next.addr       = address;
          state_next.bytes      = length;
          state_next.hidx       = 2'd0;
          state_next.poll_after = 1'b0;
          chunk_next            = '0;
          case (op)
            sfcs_pkg::OP_READ: begin
              state_next.phase = sfcs_pkg::PH_READ;
              action           = ACT_HDR;
            end
            sfcs_pkg::OP_PROG: begin
              if (length == 16'd0) begin
                action = ACT_DONE;
              end else begin
                state_next.phase = sfcs_pkg::PH_POLL;
                action           = ACT_HDR;
              end
            end
            sfcs_pkg::OP_SE, sfcs_pkg::OP_CE: begin
              state_next.phase = sfcs_pkg::PH_WREN;
              action           = ACT_HDR;
            end
            sfcs_pkg::OP_RDID: begin
              state_next.phase = sfcs_pkg::PH_ID;
              action           = ACT_HDR;
            end
            sfcs_pkg::OP_RAW: begin
              if (length == 16'd0) begin
                action = ACT_DONE;
              end else begin
                state_next.phase = sfcs_pkg::PH_RWAIT;
                action           = ACT_NEED;
              end
            end
            default: action = ACT_DONE;
          endcase
        end
      end
      sfcs_pkg::KIND_RET: begin
        case (state.phase)
          sfcs_pkg::PH_READ, sfcs_pkg::PH_ID, sfcs_pkg::PH_POLL, sfcs_pkg::PH_WRSR,
          sfcs_pkg::PH_WREN, sfcs_pkg::PH_PROG, sfcs_pkg::PH_SE, sfcs_pkg::PH_CE: begin
            got       = 1'b1;
            host_take = (state.phase == sfcs_pkg::PH_ID) && (state.hidx != 2'd0);
            if (idx_inc < sfcs_pkg::frame_len(state.phase)) begin
              state_next.hidx = idx_inc[1:0];
              action          = ACT_HDR;
            end else begin
              // frame complete
              state_next.hidx = 2'd0;
              case (state.phase)
                sfcs_pkg::PH_READ: begin
                  if (state.bytes != 16'd0) begin
                    state_next.phase = sfcs_pkg::PH_RDDATA;
                    action           = ACT_FILL;
                  end else begin
                    state_next.phase = sfcs_pkg::PH_IDLE;
                    action           = ACT_DONE;
                  end
                end
                sfcs_pkg::PH_POLL: begin
                  if (data[0]) begin
                    action = ACT_HDR;
                  end else if (state.op == sfcs_pkg::OP_PROG) begin
                    if (!state.poll_after) begin
                      state_next.phase = sfcs_pkg::PH_WRSR;
                      action           = ACT_HDR;
                    end else begin
                      state_next.poll_after = 1'b0;
                      if (state.bytes != 16'd0) begin
                        action = ACT_HDR;
                      end else begin
                        state_next.phase = sfcs_pkg::PH_IDLE;
                        action           = ACT_DONE;
                      end
                    end
                  end else begin
                    state_next.phase = sfcs_pkg::PH_IDLE;
                    action           = ACT_DONE;
                  end
                end
                sfcs_pkg::PH_WRSR: begin
                  state_next.phase = sfcs_pkg::PH_WREN;
                  action           = ACT_HDR;
                end
                sfcs_pkg::PH_WREN: begin
                  action = ACT_HDR;
                  if (state.op == sfcs_pkg::OP_PROG) begin
                    chunk_next       = chunk_first;
                    state_next.phase = sfcs_pkg::PH_PROG;
                  end else if (state.op == sfcs_pkg::OP_SE) begin
                    state_next.phase = sfcs_pkg::PH_SE;
                  end else begin
                    state_next.phase = sfcs_pkg::PH_CE;
                  end
                end
                sfcs_pkg::PH_PROG: begin
                  state_next.phase = sfcs_pkg::PH_PWAIT;
                  action           = ACT_NEED;
                end
                sfcs_pkg::PH_SE, sfcs_pkg::PH_CE: begin
                  state_next.poll_after = 1'b1;
                  state_next.phase      = sfcs_pkg::PH_POLL;
                  action                = ACT_HDR;
                end
                default: begin
                  state_next.phase = sfcs_pkg::PH_IDLE;
                  action           = ACT_DONE;
                end
              endcase
            end
          end
          sfcs_pkg::PH_RDDATA: begin
            got              = 1'b1;
            host_take        = 1'b1;
            state_next.bytes = bytes_dec;
            if (bytes_dec != 16'd0) begin
              action = ACT_FILL;
            end else begin
              state_next.phase = sfcs_pkg::PH_IDLE;
              action           = ACT_DONE;
            end
          end
          sfcs_pkg::PH_RAW: begin
            got              = 1'b1;
            host_take        = 1'b1;
            state_next.bytes = bytes_dec;
            if (bytes_dec != 16'd0) begin
              state_next.phase = sfcs_pkg::PH_RWAIT;
              action           = ACT_NEED;
            end else begin
              state_next.phase = sfcs_pkg::PH_IDLE;
              action           = ACT_DONE;
            end
          end
          sfcs_pkg::PH_PDATA: begin
            got              = 1'b1;
            state_next.bytes = bytes_dec;
            chunk_next       = chunk_dec;
            if (chunk_dec != '0) begin
              state_next.phase = sfcs_pkg::PH_PWAIT;
              action           = ACT_NEED;
            end else begin
              state_next.poll_after = 1'b1;
              state_next.phase      = sfcs_pkg::PH_POLL;
              state_next.hidx       = 2'd0;
              action                = ACT_HDR;
            end
          end
          default: got = 1'b0;
        endcase
      end
      sfcs_pkg::KIND_DATA: begin
        if (state.phase == sfcs_pkg::PH_RWAIT) begin
          got              = 1'b1;
          action           = ACT_RAWB;
          state_next.hidx  = 2'd1;
          state_next.phase = sfcs_pkg::PH_RAW;
        end else if (state.phase == sfcs_pkg::PH_PWAIT) begin
          got              = 1'b1;
          action           = ACT_PROGB;
          state_next.addr  = state.addr + 24'd1;
          state_next.phase = sfcs_pkg::PH_PDATA;
        end
      end
      default: got = 1'b0;
    endcase
  end

  // result fields from the chosen action
  always_comb begin
    res            = '0;
    res_valid      = got;
    res.host_valid = host_take;
    res.host_byte  = host_take ? data : 8'h00;
    case (action)
      ACT_HDR: begin
        res.bus = sfcs_pkg::header_bus(state_next.phase, state_next.hidx, state_next.addr,
                                       state_next.bytes == 16'd0);
      end
      ACT_FILL: begin
        res.bus = '{bv: 1'b1, bb: 8'h00, sel: 1'b0, rel: state_next.bytes == 16'd1};
      end
      ACT_RAWB: begin
        res.bus = '{bv: 1'b1, bb: data, sel: state.hidx == 2'd0,
                    rel: state.bytes == 16'd1};
      end
      ACT_PROGB: begin
        res.bus = '{bv: 1'b1, bb: data, sel: 1'b0, rel: chunk == CW'(1)};
      end
      ACT_NEED: res.need_data = 1'b1;
      ACT_DONE: res.done_res  = 1'b1;
      default:  res.bus       = '0;
    endcase
  end

endmodule

// File: rtl/spi_flash_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer_top
// byte-level spi nor flash command sequencer with registered in/out stages
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | kind, op, address, length, data
//  out     | out_valid/out_stall | bus_valid, bus_byte, select_before,
//          |                     | release_after, host_valid, host_byte,
//          |                     | need_data, done_res
//
//  one item per cycle sustained while out_stall is low; a result passes the input
//  register, then the result register, in a single sequencer pass
//  rst is synchronous and clears both stage valids and the sequencer state
//  out_stall on a full result register holds the input register, which then
//  raises in_stall; at most two items are held inside, one in each register
//  items that cause no result (ignored commands, bytes or kinds) pass through
//  without changing the state or the result register
//
module spi_flash_command_sequencer_top #(
  parameter int CHUNK_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [2:0]  op,
  input  logic [23:0] address,
  input  logic [15:0] length,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        bus_valid,
  output logic [7:0]  bus_byte,
  output logic        select_before,
  output logic        release_after,
  output logic        host_valid,
  output logic [7:0]  host_byte,
  output logic        need_data,
  output logic        done_res
);

  localparam int CW = $clog2(CHUNK_BYTES + 1);

  // input register
  logic        item_valid;
  logic [1:0]  item_kind;
  logic [2:0]  item_op;
  logic [23:0] item_address;
  logic [15:0] item_length;
  logic [7:0]  item_data;

  // sequencer state
  sfcs_pkg::st_t state;
  sfcs_pkg::st_t state_next;
  logic [CW-1:0] chunk;
  logic [CW-1:0] chunk_next;

  // result register
  sfcs_pkg::res_t res;
  sfcs_pkg::res_t res_next;
  logic           res_got;

  logic advance;

  // the held item moves on when the result register is free or draining
  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_kind    <= kind;
      item_op      <= op;
      item_address <= address;
      item_length  <= length;
      item_data    <= data;
    end
  end

  sfcs_core #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_core (
    .kind       (item_kind),
    .op         (item_op),
    .address    (item_address),
    .length     (item_length),
    .data       (item_data),
    .state      (state),
    .chunk      (chunk),
    .state_next (state_next),
    .chunk_next (chunk_next),
    .res_valid  (res_got),
    .res        (res_next)
  );

  // state commits as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfcs_pkg::ST_RESET;
      chunk <= '0;
    end else if (item_valid && advance) begin
      state <= state_next;
      chunk <= chunk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && res_got;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && res_got) begin
      res <= res_next;
    end
  end

  assign bus_valid     = res.bus.bv;
  assign bus_byte      = res.bus.bb;
  assign select_before = res.bus.sel;
  assign release_after = res.bus.rel;
  assign host_valid    = res.host_valid;
  assign host_byte     = res.host_byte;
  assign need_data     = res.need_data;
  assign done_res      = res.done_res;

  `include "spi_flash_command_sequencer_top_defines.svh"

  // every transfer out carries some action
  `SFCS_ASSERT_NOW(a_res_nonempty, out_valid, bus_valid || host_valid || need_data || done_res)
  // a finished operation never shifts out or asks for data in the same transfer
  `SFCS_ASSERT_NOW(a_done_alone, out_valid && done_res, !bus_valid && !need_data)
  // framing marks only ride on a bus byte
  `SFCS_ASSERT_NOW(a_frame_marks, out_valid && (select_before || release_after), bus_valid)
  // a held item stays held while the result register is blocked
  `SFCS_ASSERT_NEXT(a_item_held, item_valid && out_valid && out_stall, item_valid)

endmodule

// File: tb/flash_sequencer_tb_pkg.sv
// ----------------------------------------------------------------------------
// flash sequencer test package
// result record and a cycle-free mirror of the flash command sequencer that
// tracks each transfer in and checks every result transfer in order
// ----------------------------------------------------------------------------
package flash_sequencer_tb_pkg;

  typedef struct packed {
    logic       bus_valid;
    logic [7:0] bus_byte;
    logic       select_before;
    logic       release_after;
    logic       host_valid;
    logic [7:0] host_byte;
    logic       need_data;
    logic       done_res;
  } flash_step_t;

  class flash_sequence_mirror #(int CHUNK = 256);
    sfcs_pkg::phase_t phase;
    logic [2:0]  cur_op;
    logic [23:0] addr_cnt;
    logic [15:0] bytes_left;
    logic [12:0] chunk_left;
    logic [2:0]  hdr_idx;
    logic        poll_after;
    flash_step_t step;
    flash_step_t steps_due[$];
    int          errors;

    function new();
      phase      = sfcs_pkg::PH_IDLE;
      cur_op     = '0;
      addr_cnt   = '0;
      bytes_left = '0;
      chunk_left = '0;
      hdr_idx    = '0;
      poll_after = 1'b0;
      errors     = 0;
    endfunction

    function int header_len();
      case (phase)
        sfcs_pkg::PH_WREN, sfcs_pkg::PH_CE:   return 1;
        sfcs_pkg::PH_POLL, sfcs_pkg::PH_WRSR: return 2;
        default:                              return 4;
      endcase
    endfunction

    function void put_bus(logic [7:0] b, logic sel, logic rel);
      step.bus_valid     = 1'b1;
      step.bus_byte      = b;
      step.select_before = sel;
      step.release_after = rel;
    endfunction

    // header byte at hdr_idx of the frame in progress
    function void put_header();
      logic [7:0] addr_sel;
      logic [7:0] b;
      logic       closes;
      case (hdr_idx)
        3'd1:    addr_sel = addr_cnt[23:16];
        3'd2:    addr_sel = addr_cnt[15:8];
        default: addr_sel = addr_cnt[7:0];
      endcase
      case (phase)
        sfcs_pkg::PH_READ: b = (hdr_idx == 0) ? sfcs_pkg::CMD_READ : addr_sel;
        sfcs_pkg::PH_ID:   b = (hdr_idx == 0) ? sfcs_pkg::CMD_RDID : 8'h00;
        sfcs_pkg::PH_POLL: b = (hdr_idx == 0) ? sfcs_pkg::CMD_RDSR : sfcs_pkg::POLL_FILL;
        sfcs_pkg::PH_WRSR: b = (hdr_idx == 0) ? sfcs_pkg::CMD_WRSR : sfcs_pkg::SR_VALUE;
        sfcs_pkg::PH_WREN: b = sfcs_pkg::CMD_WREN;
        sfcs_pkg::PH_PROG: b = (hdr_idx == 0) ? sfcs_pkg::CMD_PROG : addr_sel;
        sfcs_pkg::PH_SE:   b = (hdr_idx == 0) ? sfcs_pkg::CMD_SE : addr_sel;
        sfcs_pkg::PH_CE:   b = sfcs_pkg::CMD_CE;
        default:           b = 8'h00;
      endcase
      // program header leaves the frame open for data, read only closes when empty
      if (phase == sfcs_pkg::PH_PROG) begin
        closes = 1'b0;
      end else if (phase == sfcs_pkg::PH_READ) begin
        closes = (bytes_left == 0);
      end else begin
        closes = 1'b1;
      end
      put_bus(b, hdr_idx == 0, (hdr_idx + 1 == header_len()) && closes);
    endfunction

    function void open_frame(sfcs_pkg::phase_t ph);
      phase   = ph;
      hdr_idx = '0;
      put_header();
    endfunction

    function void finish_op();
      phase         = sfcs_pkg::PH_IDLE;
      step.done_res = 1'b1;
    endfunction

    // advance on one accepted transfer; returns 1 when a result is due
    function bit note_transfer(logic [1:0] k, logic [2:0] o, logic [23:0] a,
                               logic [15:0] l, logic [7:0] d);
      bit took;
      took = 1'b0;
      step = '0;
      case (k)
        sfcs_pkg::KIND_CMD: begin
          if (phase == sfcs_pkg::PH_IDLE) begin
            took       = 1'b1;
            cur_op     = o;
            addr_cnt   = a;
            bytes_left = l;
            chunk_left = '0;
            hdr_idx    = '0;
            poll_after = 1'b0;
            case (o)
              sfcs_pkg::OP_READ: open_frame(sfcs_pkg::PH_READ);
              sfcs_pkg::OP_PROG: begin
                if (l == 0) finish_op();
                else open_frame(sfcs_pkg::PH_POLL);
              end
              sfcs_pkg::OP_SE, sfcs_pkg::OP_CE: open_frame(sfcs_pkg::PH_WREN);
              sfcs_pkg::OP_RDID: open_frame(sfcs_pkg::PH_ID);
              sfcs_pkg::OP_RAW: begin
                if (l == 0) begin
                  finish_op();
                end else begin
                  phase          = sfcs_pkg::PH_RWAIT;
                  step.need_data = 1'b1;
                end
              end
              default: finish_op();
            endcase
          end
        end
        sfcs_pkg::KIND_RET: begin
          case (phase)
            sfcs_pkg::PH_READ, sfcs_pkg::PH_ID, sfcs_pkg::PH_POLL, sfcs_pkg::PH_WRSR,
            sfcs_pkg::PH_WREN, sfcs_pkg::PH_PROG, sfcs_pkg::PH_SE, sfcs_pkg::PH_CE: begin
              took = 1'b1;
              if (phase == sfcs_pkg::PH_ID && hdr_idx != 0) begin
                step.host_valid = 1'b1;
                step.host_byte  = d;
              end
              if (hdr_idx + 1 < header_len()) begin
                hdr_idx++;
                put_header();
              end else begin
                case (phase)
                  sfcs_pkg::PH_READ: begin
                    if (bytes_left > 0) begin
                      phase = sfcs_pkg::PH_RDDATA;
                      put_bus(8'h00, 1'b0, bytes_left == 1);
                    end else begin
                      finish_op();
                    end
                  end
                  sfcs_pkg::PH_POLL: begin
                    if (d[0]) begin
                      open_frame(sfcs_pkg::PH_POLL);
                    end else if (cur_op == sfcs_pkg::OP_PROG) begin
                      if (!poll_after) begin
                        open_frame(sfcs_pkg::PH_WRSR);
                      end else begin
                        poll_after = 1'b0;
                        if (bytes_left > 0) open_frame(sfcs_pkg::PH_POLL);
                        else finish_op();
                      end
                    end else begin
                      finish_op();
                    end
                  end
                  sfcs_pkg::PH_WRSR: open_frame(sfcs_pkg::PH_WREN);
                  sfcs_pkg::PH_WREN: begin
                    if (cur_op == sfcs_pkg::OP_PROG) begin
                      chunk_left = (bytes_left < CHUNK) ? 13'(bytes_left) : 13'(CHUNK);
                      open_frame(sfcs_pkg::PH_PROG);
                    end else if (cur_op == sfcs_pkg::OP_SE) begin
                      open_frame(sfcs_pkg::PH_SE);
                    end else begin
                      open_frame(sfcs_pkg::PH_CE);
                    end
                  end
                  sfcs_pkg::PH_PROG: begin
                    phase          = sfcs_pkg::PH_PWAIT;
                    step.need_data = 1'b1;
                  end
                  sfcs_pkg::PH_SE, sfcs_pkg::PH_CE: begin
                    poll_after = 1'b1;
                    open_frame(sfcs_pkg::PH_POLL);
                  end
                  default: finish_op();
                endcase
              end
            end
            sfcs_pkg::PH_RDDATA: begin
              took            = 1'b1;
              step.host_valid = 1'b1;
              step.host_byte  = d;
              if (bytes_left > 0) bytes_left--;
              if (bytes_left > 0) put_bus(8'h00, 1'b0, bytes_left == 1);
              else finish_op();
            end
            sfcs_pkg::PH_RAW: begin
              took            = 1'b1;
              step.host_valid = 1'b1;
              step.host_byte  = d;
              if (bytes_left > 0) bytes_left--;
              if (bytes_left > 0) begin
                phase          = sfcs_pkg::PH_RWAIT;
                step.need_data = 1'b1;
              end else begin
                finish_op();
              end
            end
            sfcs_pkg::PH_PDATA: begin
              took = 1'b1;
              if (bytes_left > 0) bytes_left--;
              if (chunk_left > 0) chunk_left--;
              if (chunk_left > 0) begin
                phase          = sfcs_pkg::PH_PWAIT;
                step.need_data = 1'b1;
              end else begin
                poll_after = 1'b1;
                open_frame(sfcs_pkg::PH_POLL);
              end
            end
            default: took = 1'b0;
          endcase
        end
        sfcs_pkg::KIND_DATA: begin
          if (phase == sfcs_pkg::PH_RWAIT) begin
            took = 1'b1;
            put_bus(d, hdr_idx == 0, bytes_left == 1);
            hdr_idx = 3'd1;
            phase   = sfcs_pkg::PH_RAW;
          end else if (phase == sfcs_pkg::PH_PWAIT) begin
            took = 1'b1;
            put_bus(d, 1'b0, chunk_left == 1);
            addr_cnt = addr_cnt + 24'd1;
            phase    = sfcs_pkg::PH_PDATA;
          end
        end
        default: took = 1'b0;
      endcase
      if (took) steps_due.push_back(step);
      return took;
    endfunction

    function void compare_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
        $error("%s: expected %0h, got %0h", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_response(flash_step_t got);
      flash_step_t want;
      if (steps_due.size() == 0) begin
        $error("result transfer with nothing due: bus %0b/%0h host %0b/%0h done %0b",
               got.bus_valid, got.bus_byte, got.host_valid, got.host_byte, got.done_res);
        errors++;
        return;
      end
      want = steps_due.pop_front();
      compare_field("bus_valid", int'(want.bus_valid), int'(got.bus_valid));
      compare_field("bus_byte", int'(want.bus_byte), int'(got.bus_byte));
      compare_field("select_before", int'(want.select_before), int'(got.select_before));
      compare_field("release_after", int'(want.release_after), int'(got.release_after));
      compare_field("host_valid", int'(want.host_valid), int'(got.host_valid));
      compare_field("host_byte", int'(want.host_byte), int'(got.host_byte));
      compare_field("need_data", int'(want.need_data), int'(got.need_data));
      compare_field("done_res", int'(want.done_res), int'(got.done_res));
    endfunction
  endclass

endpackage

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// spi flash command sequencer testbench
// plays both the host and the flash: commands, returned flash bytes and host
// data bytes are chosen from the mirrored sequencer phase, so most traffic
// walks whole operations; every result transfer is checked field by field
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHUNK_BYTES    = 256;
  localparam int RANDOM_RESULTS = 800;
  localparam int MAX_GAP        = 12;
  localparam int LONG_HOLD      = 250;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TIMEOUT_NS     = 10_000_000;

  // op codes the block has no operation for
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [1:0]  kind      = sfcs_pkg::KIND_NONE;
  logic [2:0]  op        = sfcs_pkg::OP_READ;
  logic [23:0] address   = '0;
  logic [15:0] length    = '0;
  logic [7:0]  data      = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        bus_valid;
  logic [7:0]  bus_byte;
  logic        select_before;
  logic        release_after;
  logic        host_valid;
  logic [7:0]  host_byte;
  logic        need_data;
  logic        done_res;

  // next transfer chosen by the item builder
  logic [1:0]  nx_kind;
  logic [2:0]  nx_op;
  logic [23:0] nx_addr;
  logic [15:0] nx_len;
  logic [7:0]  nx_data;

  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  int busy_left   = 0;

  flash_sequencer_tb_pkg::flash_sequence_mirror #(CHUNK_BYTES) mirror = new();

  spi_flash_command_sequencer_top #(.CHUNK_BYTES(CHUNK_BYTES)) DUT (.*);

  always #10 clk = ~clk;

  // offer one input transfer after a random gap and hold it until taken
  task automatic transfer(input logic [1:0] k, input logic [2:0] o, input logic [23:0] a,
                          input logic [15:0] l, input logic [7:0] d, output bit counted);
    int gap;
    gap = send_steady ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind     <= k;
    op       <= o;
    address  <= a;
    length   <= l;
    data     <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    counted = mirror.note_transfer(k, o, a, l, d);
  endtask

  // pick the next transfer from the mirrored phase; with stray set, about one
  // in ten is noise (wrong kind, command while busy, unused kind)
  task automatic make_item(input bit stray);
    nx_kind = 2'($urandom_range(3, 0));
    nx_op   = 3'($urandom_range(7, 0));
    nx_addr = 24'($urandom());
    nx_len  = 16'($urandom());
    if ($urandom_range(7, 0) == 0) begin
      nx_data = $urandom_range(1, 0) ? 8'hFF : 8'h00;
    end else begin
      nx_data = 8'($urandom());
    end
    if (stray && $urandom_range(9, 0) == 0) begin
      // a stray command that does start an operation keeps its length short
      if (mirror.phase == sfcs_pkg::PH_IDLE && nx_kind == sfcs_pkg::KIND_CMD) begin
        nx_len = nx_len & 16'h000F;
      end
    end else begin
      case (mirror.phase)
        sfcs_pkg::PH_IDLE: begin
          nx_kind = sfcs_pkg::KIND_CMD;
          if ($urandom_range(15, 0) == 0) begin
            nx_op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
          end else begin
            nx_op = 3'($urandom_range(sfcs_pkg::OP_RAW, sfcs_pkg::OP_READ));
          end
          // addresses close to the top exercise the counter wrap
          if ($urandom_range(7, 0) == 0) nx_addr = 24'hFFFFFF - 24'($urandom_range(3, 0));
          if (nx_op == sfcs_pkg::OP_PROG && $urandom_range(11, 0) == 0) begin
            // lengths around the chunk size, some long enough to span a chunk boundary
            nx_len = 16'($urandom_range(CHUNK_BYTES + 4, CHUNK_BYTES - 6));
          end else if (nx_op == sfcs_pkg::OP_READ || nx_op == sfcs_pkg::OP_PROG ||
                       nx_op == sfcs_pkg::OP_RAW) begin
            nx_len = 16'($urandom_range(12, 0));
          end
        end
        sfcs_pkg::PH_PWAIT, sfcs_pkg::PH_RWAIT: nx_kind = sfcs_pkg::KIND_DATA;
        default: begin
          nx_kind = sfcs_pkg::KIND_RET;
          // reply to the status filler byte: bit 0 is the busy flag
          if (mirror.phase == sfcs_pkg::PH_POLL && mirror.hdr_idx == 1) begin
            if (busy_left > 0) begin
              nx_data[0] = 1'b1;
              busy_left--;
            end else begin
              nx_data[0] = stray && ($urandom_range(3, 0) == 0);
            end
          end
        end
      endcase
    end
  endtask

  // answer the operation in progress until the block is idle again
  task automatic finish_current();
    bit counted;
    while (mirror.phase != sfcs_pkg::PH_IDLE) begin
      make_item(1'b0);
      transfer(nx_kind, nx_op, nx_addr, nx_len, nx_data, counted);
    end
  endtask

  task automatic run_command(input logic [2:0] o, input logic [23:0] a, input logic [15:0] l);
    bit counted;
    transfer(sfcs_pkg::KIND_CMD, o, a, l, 8'($urandom()), counted);
    finish_current();
  endtask

  // host and flash side
  initial begin : item_side
    int produced;
    int drain;
    bit counted;
    produced = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // stray transfers while idle: flash byte, host byte, unused kind
    transfer(sfcs_pkg::KIND_RET, sfcs_pkg::OP_READ, 24'h000000, 16'h0000, 8'hFF, counted);
    transfer(sfcs_pkg::KIND_DATA, sfcs_pkg::OP_READ, 24'hFFFFFF, 16'hFFFF, 8'h00, counted);
    transfer(sfcs_pkg::KIND_NONE, OP_SPARE_HI, 24'hFFFFFF, 16'hFFFF, 8'hFF, counted);
    // read of length zero: header only, released after the last address byte
    run_command(sfcs_pkg::OP_READ, 24'h000000, 16'd0);
    run_command(sfcs_pkg::OP_READ, 24'hFFFFFF, 16'd2);
    // a second command during the id read is dropped
    transfer(sfcs_pkg::KIND_CMD, sfcs_pkg::OP_RDID, 24'h123456, 16'd1, 8'h00, counted);
    transfer(sfcs_pkg::KIND_CMD, sfcs_pkg::OP_CE, 24'h000000, 16'hFFFF, 8'h00, counted);
    finish_current();
    // program across the address wrap, flash busy at the first polls
    busy_left = 2;
    run_command(sfcs_pkg::OP_PROG, 24'hFFFFFE, 16'd3);
    run_command(sfcs_pkg::OP_PROG, 24'h000000, 16'd0);
    run_command(sfcs_pkg::OP_RAW, 24'h000000, 16'd0);
    run_command(sfcs_pkg::OP_RAW, 24'hABCDEF, 16'd2);
    busy_left = 1;
    run_command(sfcs_pkg::OP_SE, 24'h5A5A5A, 16'hFFFF);
    run_command(sfcs_pkg::OP_CE, 24'hFFFFFF, 16'd0);
    run_command(sfcs_pkg::OP_RDID, 24'h000000, 16'd0);
    run_command(OP_SPARE_LO, 24'h000000, 16'd0);
    run_command(OP_SPARE_HI, 24'hFFFFFF, 16'hFFFF);

    // random traffic, counting only transfers that produce a result
    while (produced < RANDOM_RESULTS) begin
      make_item(1'b1);
      transfer(nx_kind, nx_op, nx_addr, nx_len, nx_data, counted);
      if (counted) produced++;
      if ($urandom_range(39, 0) == 0) send_steady = !send_steady;
    end
    in_valid <= 1'b0;

    // let outstanding results drain, then settle to catch any stray ones
    drain = 0;
    while (mirror.steps_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.steps_due.size() != 0) begin
      $error("%0d result transfers never arrived", mirror.steps_due.size());
      mirror.errors++;
    end
    if (mirror.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side: random stalls, steady stretches and two long hold-offs that
  // back the block up until it stalls its input
  initial begin : result_side
    int hold;
    int taken;
    flash_sequencer_tb_pkg::flash_step_t got;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      if (taken == 150 || taken == 500) begin
        hold = LONG_HOLD;
      end else begin
        hold = recv_steady ? 0 : $urandom_range(MAX_GAP, 0);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = {bus_valid, bus_byte, select_before, release_after,
             host_valid, host_byte, need_data, done_res};
      mirror.check_response(got);
      taken++;
      if ($urandom_range(39, 0) == 0) recv_steady = !recv_steady;
    end
  end

  // hard stop if the handshakes hang
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
